>>> design/polyline_normal_offset_macros.svh
// assertion macros shared by pno_front and pno_back
`ifndef POLYLINE_NORMAL_OFFSET_MACROS_SVH
`define POLYLINE_NORMAL_OFFSET_MACROS_SVH

`define PNO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PNO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/pno_pkg.sv
`default_nettype none
package pno_pkg;
    localparam int unsigned UNIT_SHIFT = 14;
    localparam int unsigned NORM_BITS  = 30;
    localparam int unsigned OFF_WIDTH  = 32;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_norm,
        t_st_sqrt,
        t_st_div,
        t_st_mul,
        t_st_out
    } t_state;
endpackage
`default_nettype wire

>>> design/polyline_normal_offset.sv
// polyline normal offset
// points enter on i_valid/o_stall, one transfer per point, with i_last_point
// on the final point of a polyline. results leave on o_valid/i_stall.
// the result for a point is produced once the next point has arrived;
// the final point yields two results. a single-point polyline passes through.
// the offset register is written on i_cfg_valid/o_cfg_ready; the user is
// to write it only while idle, which the block does not enforce. the back
// end normalizes once per result: shifts, square root load, square root,
// divide, offset multiply, output (a zero tangent goes straight to output),
// and takes a new job from the queue only when idle. a four-entry queue lets
// the front keep taking points; o_stall is high while three or more entries
// wait and for one cycle after the final point of a multi-point polyline.
// the output register holds its transfer while i_stall is high and the back
// end waits. reset clears the window, queue and offset (to zero).
`default_nettype none
module polyline_normal_offset #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [COORD_WIDTH-1:0] i_point_x,
    input  wire logic [COORD_WIDTH-1:0] i_point_y,
    input  wire logic                   i_last_point,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [COORD_WIDTH-1:0]      o_out_x,
    output logic [COORD_WIDTH-1:0]      o_out_y,
    output logic                        o_out_last,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [31:0]            i_cfg_data
);
    import pno_pkg::*;

    logic [OFF_WIDTH-1:0]   r_offset;
    logic                   jv, jr, jl;
    logic [COORD_WIDTH-1:0] jpx, jpy;
    logic [COORD_WIDTH:0]   jdx, jdy;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_offset <= '0;
        else if (i_cfg_valid) r_offset <= i_cfg_data;
    end

    pno_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_x(i_point_x), .i_y(i_point_y), .i_last(i_last_point),
        .o_job_valid(jv), .i_job_ready(jr), .o_job_px(jpx), .o_job_py(jpy),
        .o_job_dx(jdx), .o_job_dy(jdy), .o_job_last(jl)
    );

    pno_back #(.CW(COORD_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_offset(r_offset),
        .i_job_valid(jv), .o_job_ready(jr), .i_px(jpx), .i_py(jpy),
        .i_dx(jdx), .i_dy(jdy), .i_last(jl),
        .o_valid(o_valid), .i_stall(i_stall), .o_x(o_out_x), .o_y(o_out_y),
        .o_last(o_out_last)
    );
endmodule
`default_nettype wire

>>> design/pno_front.sv
`default_nettype none
module pno_front #(
    parameter int unsigned CW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [CW-1:0] i_x,
    input  wire logic [CW-1:0] i_y,
    input  wire logic          i_last,
    output logic               o_job_valid,
    input  wire logic          i_job_ready,
    output logic [CW-1:0]      o_job_px,
    output logic [CW-1:0]      o_job_py,
    output logic [CW:0]        o_job_dx,
    output logic [CW:0]        o_job_dy,
    output logic               o_job_last
);
    import pno_pkg::*;

    // queue entry: point, tangent, last
    localparam int unsigned EW = 2 * CW + 2 * (CW + 1) + 1;
    localparam int unsigned QD = 4;

    logic [EW-1:0] r_q [QD];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;
    logic [CW-1:0] r_ox, r_oy, r_px, r_py;
    logic [1:0]    r_seen;
    logic          r_pend;
    logic [EW-1:0] r_pend_e;

    logic          acc, push, pop;
    logic [EW-1:0] push_e, e1, e2;
    logic [CW:0]   d1x, d1y, d2x, d2y;
    logic          two;

    assign pop     = o_job_valid && i_job_ready;
    // second result of a last point waits in r_pend
    assign o_stall = r_pend || (r_cnt > 3'(QD - 2));
    assign acc     = i_valid && !o_stall;

    always_comb begin
        d1x = (r_seen == 2'd2) ? ({i_x[CW-1], i_x} - {r_ox[CW-1], r_ox})
                               : ({i_x[CW-1], i_x} - {r_px[CW-1], r_px});
        d1y = (r_seen == 2'd2) ? ({i_y[CW-1], i_y} - {r_oy[CW-1], r_oy})
                               : ({i_y[CW-1], i_y} - {r_py[CW-1], r_py});
        d2x = {i_x[CW-1], i_x} - {r_px[CW-1], r_px};
        d2y = {i_y[CW-1], i_y} - {r_py[CW-1], r_py};
        e1  = {r_px, r_py, d1x, d1y, 1'b0};
        e2  = {i_x, i_y, d2x, d2y, 1'b1};
        two = 1'b0;
        push_e = e1;
        push = 1'b0;
        if (r_pend) begin
            push   = 1'b1;
            push_e = r_pend_e;
        end else if (acc) begin
            if (r_seen == 2'd0) begin
                push   = i_last;
                push_e = {i_x, i_y, {(CW + 1){1'b0}}, {(CW + 1){1'b0}}, 1'b1};
            end else begin
                push = 1'b1;
                two  = i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_seen <= '0;
            r_pend <= 1'b0;
            r_ox <= '0; r_oy <= '0; r_px <= '0; r_py <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= push_e;
                r_wp      <= r_wp + 2'd1;
            end
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
            if (r_pend) r_pend <= 1'b0;
            if (two) begin
                r_pend   <= 1'b1;
                r_pend_e <= e2;
            end
            if (acc) begin
                if (i_last) begin
                    r_seen <= '0;
                    r_ox <= '0; r_oy <= '0; r_px <= '0; r_py <= '0;
                end else begin
                    r_seen <= (r_seen == 2'd0) ? 2'd1 : 2'd2;
                    r_ox <= r_px; r_oy <= r_py;
                    r_px <= i_x;  r_py <= i_y;
                end
            end
        end
    end

    assign o_job_valid = (r_cnt != 3'd0);
    assign {o_job_px, o_job_py, o_job_dx, o_job_dy, o_job_last} = r_q[r_rp];

    `include "polyline_normal_offset_macros.svh"
    `PNO_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(QD))
    `PNO_ASSERT_NXT(a_pend_push, i_clk, i_rst_n, two, r_pend && push)
    `PNO_ASSERT_IMP(a_no_acc_pend, i_clk, i_rst_n, r_pend, !acc)
endmodule
`default_nettype wire

>>> design/pno_back.sv
`default_nettype none
module pno_back #(
    parameter int unsigned CW = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [pno_pkg::OFF_WIDTH-1:0] i_offset,
    input  wire logic                         i_job_valid,
    output logic                              o_job_ready,
    input  wire logic [CW-1:0]                i_px,
    input  wire logic [CW-1:0]                i_py,
    input  wire logic [CW:0]                  i_dx,
    input  wire logic [CW:0]                  i_dy,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [CW-1:0]                     o_x,
    output logic [CW-1:0]                     o_y,
    output logic                              o_last
);
    import pno_pkg::*;

    localparam int unsigned NB = NORM_BITS;
    localparam int unsigned SB = 2 * NB + 2;
    localparam int unsigned LB = NB + 2;
    localparam int unsigned QB = UNIT_SHIFT + 2;
    localparam int unsigned DN = NB + UNIT_SHIFT + 2;
    localparam int unsigned PW = OFF_WIDTH + QB + 1;
    localparam int unsigned AW = (CW > NB) ? CW + 1 : NB + 1;
    localparam int unsigned XW = ((CW > OFF_WIDTH) ? CW : OFF_WIDTH) + 2;

    t_state r_st, n_st;
    logic [CW-1:0] r_px, r_py;
    logic          r_last, r_sx, r_sy, r_zero;
    logic [AW-1:0] r_ax, r_ay;
    logic [SB-1:0] r_n, r_res, r_bit;
    logic [DN-1:0] r_remx, r_remy;
    logic [QB-1:0] r_ux, r_uy;
    logic [5:0]    r_cnt;
    logic [CW-1:0] r_ox, r_oy;
    logic          r_ov;

    logic [CW:0]   mx, my;
    logic [SB-1:0] sum_sq, tr;
    logic [LB-1:0] len;
    logic [DN-1:0] denx;
    logic signed [PW-1:0] px, py;
    logic signed [OFF_WIDTH+1:0] sx, sy;
    logic signed [XW-1:0] nx, ny;
    logic          out_take;

    assign out_take    = !r_ov || !i_stall;
    assign o_job_ready = (r_st == t_st_idle);
    assign len  = r_res[LB-1:0];
    assign mx   = i_dx[CW] ? -i_dx : i_dx;
    assign my   = i_dy[CW] ? -i_dy : i_dy;
    assign tr   = r_res + r_bit;
    assign denx = DN'(len) << r_cnt[3:0];
    assign sum_sq = SB'(r_ax[NB-1:0]) * SB'(r_ax[NB-1:0])
                  + SB'(r_ay[NB-1:0]) * SB'(r_ay[NB-1:0]);

    function automatic logic signed [OFF_WIDTH+1:0] rnd(input logic signed [PW-1:0] p);
        logic [PW-1:0] m;
        logic [PW-1:0] q;
        begin
            m = p[PW-1] ? -p : p;
            q = (m + (PW'(1) << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
            rnd = p[PW-1] ? -(OFF_WIDTH + 2)'(q) : (OFF_WIDTH + 2)'(q);
        end
    endfunction

    function automatic logic [CW-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi, lo;
        begin
            hi = XW'({1'b0, {(CW - 1){1'b1}}});
            lo = ~hi;
            sat = (v > hi) ? hi[CW-1:0] : (v < lo) ? lo[CW-1:0] : v[CW-1:0];
        end
    endfunction

    always_comb begin
        px = $signed({{(PW-OFF_WIDTH){i_offset[OFF_WIDTH-1]}}, i_offset})
           * $signed(r_sy ? -PW'(r_uy) : PW'(r_uy));
        py = $signed({{(PW-OFF_WIDTH){i_offset[OFF_WIDTH-1]}}, i_offset})
           * $signed(r_sx ? -PW'(r_ux) : PW'(r_ux));
        sx = -rnd(px);
        sy = rnd(py);
        nx = XW'($signed(r_px)) + XW'(sx);
        ny = XW'($signed(r_py)) + XW'(sy);
        if (r_zero) begin
            nx = XW'($signed(r_px));
            ny = XW'($signed(r_py));
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_st_idle: if (i_job_valid) n_st = t_st_norm;
            t_st_norm: begin
                if (r_zero) n_st = t_st_out;
                else if (((r_ax | r_ay) >> NB) == '0 && ((r_ax | r_ay) >> (NB - 1)) != '0)
                    n_st = t_st_sqrt;
            end
            t_st_sqrt: if (r_bit == '0) n_st = t_st_div;
            t_st_div:  if (r_cnt == '0) n_st = t_st_mul;
            t_st_mul:  n_st = t_st_out;
            t_st_out:  if (out_take) n_st = t_st_idle;
            default:   n_st = t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_st_idle;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (r_st == t_st_out && out_take) r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            t_st_idle: begin
                r_px <= i_px; r_py <= i_py; r_last <= i_last;
                r_sx <= i_dx[CW]; r_sy <= i_dy[CW];
                r_ax <= AW'(mx); r_ay <= AW'(my);
                r_zero <= (mx | my) == '0;
                r_ux <= '0; r_uy <= '0;
            end
            t_st_norm: begin
                if (((r_ax | r_ay) >> NB) != '0) begin
                    r_ax <= r_ax >> 1; r_ay <= r_ay >> 1;
                end else if (((r_ax | r_ay) >> (NB - 1)) == '0) begin
                    r_ax <= r_ax << 1; r_ay <= r_ay << 1;
                end else begin
                    r_n   <= sum_sq;
                    r_res <= '0;
                    r_bit <= SB'(1) << (SB - 2);
                end
            end
            t_st_sqrt: begin
                if (r_bit != '0) begin
                    if (r_n >= tr) begin
                        r_n   <= r_n - tr;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                r_cnt <= 6'(QB - 1);
                r_remx <= DN'(r_ax[NB-1:0]) * DN'(1 << UNIT_SHIFT);
                r_remy <= DN'(r_ay[NB-1:0]) * DN'(1 << UNIT_SHIFT);
            end
            t_st_div: begin
                if (r_cnt == 6'(QB - 1)) begin
                    r_remx <= r_remx + DN'(len >> 1) - ((r_remx + DN'(len >> 1)) >= denx ? denx : '0);
                    r_remy <= r_remy + DN'(len >> 1) - ((r_remy + DN'(len >> 1)) >= denx ? denx : '0);
                    r_ux[r_cnt[3:0]] <= (r_remx + DN'(len >> 1)) >= denx;
                    r_uy[r_cnt[3:0]] <= (r_remy + DN'(len >> 1)) >= denx;
                end else begin
                    r_remx <= r_remx - (r_remx >= denx ? denx : '0);
                    r_remy <= r_remy - (r_remy >= denx ? denx : '0);
                    r_ux[r_cnt[3:0]] <= r_remx >= denx;
                    r_uy[r_cnt[3:0]] <= r_remy >= denx;
                end
                if (r_cnt != '0) r_cnt <= r_cnt - 6'd1;
            end
            t_st_mul: ;
            t_st_out: begin
                if (out_take) begin
                    r_ox <= sat(nx);
                    r_oy <= sat(ny);
                    o_last <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ov;
    assign o_x = r_ox;
    assign o_y = r_oy;

    `include "polyline_normal_offset_macros.svh"
    `PNO_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ov && i_stall, r_ov && $stable(r_ox))
    `PNO_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_st != t_st_idle, !o_job_ready)
    `PNO_ASSERT_IMP(a_div_cnt, i_clk, i_rst_n, r_st == t_st_div, r_cnt < 6'(QB))
endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int CW = 32;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_POLYLINES = 168;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } point_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [CW-1:0] i_point_x = '0;
    logic [CW-1:0] i_point_y = '0;
    logic          i_last_point = 1'b0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [CW-1:0] o_out_x;
    logic [CW-1:0] o_out_y;
    logic          o_out_last;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [31:0]   i_cfg_data = '0;

    polyline_normal_offset #(.COORD_WIDTH(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_last_point(i_last_point),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_last(o_out_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    point_t        pending_points[$];
    point_t        expected_offsets[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            quiet_phase = 1'b0;
    int            send_gap = 0;
    int            stall_left = 0;

    // predictor state
    logic signed [31:0] offset_q;
    logic signed [63:0] older_x, older_y, prev_x, prev_y;
    int                 held_count;

    task automatic queue_point(point_t p);
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic queue_expected(point_t p);
        expected_offsets.insert(expected_offsets.size(), p);
    endtask

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] shift_by(logic signed [63:0] u);
        logic signed [63:0] p;
        logic [63:0] m;
        p = 64'(offset_q) * u;
        m = (abs64(p) + 64'd8192) >> 14;
        return p < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [CW-1:0] clamp(logic signed [63:0] v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[CW-1:0];
    endfunction

    function automatic point_t offset_point(logic signed [63:0] px, logic signed [63:0] py,
                                            logic signed [63:0] dx, logic signed [63:0] dy,
                                            logic lst);
        logic [63:0] ax, ay, len, ux, uy;
        logic signed [63:0] tx, ty, x, y;
        point_t r;
        x = px;
        y = py;
        ax = abs64(dx);
        ay = abs64(dy);
        if ((ax | ay) != 0) begin
            while ((ax | ay) >= (64'd1 << 30)) begin
                ax = ax >> 1;
                ay = ay >> 1;
            end
            while ((ax | ay) < (64'd1 << 29)) begin
                ax = ax << 1;
                ay = ay << 1;
            end
            len = int_sqrt(ax * ax + ay * ay);
            ux = (ax * 16384 + len / 2) / len;
            uy = (ay * 16384 + len / 2) / len;
            tx = dx < 0 ? -$signed(ux) : $signed(ux);
            ty = dy < 0 ? -$signed(uy) : $signed(uy);
            x = x + shift_by(-ty);
            y = y + shift_by(tx);
        end
        r.x = clamp(x);
        r.y = clamp(y);
        r.last = lst;
        return r;
    endfunction

    task automatic predict_point(point_t p);
        logic signed [63:0] cx, cy;
        cx = $signed(p.x);
        cy = $signed(p.y);
        if (held_count == 0) begin
            if (p.last) queue_expected(offset_point(cx, cy, 0, 0, 1'b1));
            else begin
                prev_x = cx;
                prev_y = cy;
                held_count = 1;
            end
        end else begin
            if (held_count == 1)
                queue_expected(offset_point(prev_x, prev_y,
                    cx - prev_x, cy - prev_y, 1'b0));
            else
                queue_expected(offset_point(prev_x, prev_y,
                    cx - older_x, cy - older_y, 1'b0));
            if (p.last) begin
                queue_expected(offset_point(cx, cy,
                    cx - prev_x, cy - prev_y, 1'b1));
                older_x = 0; older_y = 0; prev_x = 0; prev_y = 0;
                held_count = 0;
            end else begin
                older_x = prev_x;
                older_y = prev_y;
                prev_x = cx;
                prev_y = cy;
                held_count = 2;
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_point('{i_point_x, i_point_y, i_last_point});
                void'(pending_points.pop_front());
            end
            if (i_valid && o_stall) begin
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(1, 11) - 1;
                i_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                point_t nx;
                nx = pending_points[0];
                i_valid <= 1'b1;
                i_point_x <= nx.x;
                i_point_y <= nx.y;
                i_last_point <= nx.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_offsets.size() == 0) begin
                    report_mismatch("unexpected transfer", o_out_x, '0);
                end else begin
                    point_t e;
                    e = expected_offsets.pop_front();
                    if (o_out_x !== e.x) report_mismatch("out_x", o_out_x, e.x);
                    if (o_out_y !== e.y) report_mismatch("out_y", o_out_y, e.y);
                    if (o_out_last !== e.last) report_mismatch("out_last", o_out_last, e.last);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 11) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("polyline_normal_offset test failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_points.size() > 0 || i_valid || expected_offsets.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        offset_q = v;
    endtask

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
        endcase
    endfunction

    task automatic add_polyline(int n, int mode);
        logic [CW-1:0] bx, by;
        bx = rand_coord(3);
        by = rand_coord(3);
        for (int k = 0; k < n; k++) begin
            point_t p;
            if (mode == 0) begin
                bx = bx + $urandom_range(0, 32'h3ffff) - 32'h1ffff;
                by = by + $urandom_range(0, 32'h3ffff) - 32'h1ffff;
                p.x = bx;
                p.y = by;
            end else begin
                p.x = rand_coord($urandom_range(0, 3));
                p.y = rand_coord($urandom_range(0, 3));
            end
            p.last = (k == n - 1);
            queue_point(p);
        end
    endtask

    logic [31:0] offset_set[6] = '{32'h00004000, 32'h7fffffff, 32'h80000000,
                                   32'hffff0000, 32'h00000001, 32'h0};

    initial begin
        offset_q = 0;
        older_x = 0; older_y = 0; prev_x = 0; prev_y = 0;
        held_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_offset(32'h00002000);
        // directed: single point, zero tangent, extremes, two-point line
        queue_point('{32'h00001000, 32'hfffff000, 1'b1});
        queue_point('{32'h7fffffff, 32'h7fffffff, 1'b1});
        queue_point('{32'h00010000, 32'h00020000, 1'b0});
        queue_point('{32'h00010000, 32'h00020000, 1'b1});
        queue_point('{32'h80000000, 32'h80000000, 1'b0});
        queue_point('{32'h7fffffff, 32'h7fffffff, 1'b0});
        queue_point('{32'h80000000, 32'h7fffffff, 1'b0});
        queue_point('{32'h7fffffff, 32'h80000000, 1'b1});
        queue_point('{32'h0, 32'h0, 1'b0});
        queue_point('{32'h00001000, 32'h0, 1'b0});
        queue_point('{32'h00001000, 32'h0, 1'b0});
        queue_point('{32'h00002000, 32'h00000001, 1'b0});
        queue_point('{32'hffffffff, 32'h00000002, 1'b1});
        wait_idle();
        for (int s = 0; s < 6; s++) begin
            write_offset(s == 5 ? $urandom() : offset_set[s]);
            for (int j = 0; j < RANDOM_POLYLINES / 6; j++)
                add_polyline($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 5),
                             $urandom_range(0, 3) == 0);
            if (s == 5) quiet_phase = 1'b1;
            wait_idle();
        end
        if (error_count == 0) begin
            $display("polyline_normal_offset test passed");
        end else begin
            $display("polyline_normal_offset test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
